@@ hdl/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, codes and constants for the sprite mask collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

  localparam int MAX_SIDE = 64;
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int SIZE_W   = $clog2(MAX_SIDE + 1);
  localparam int CFG_W    = 7;
  localparam int POS_W    = 16;
  localparam int PIX_W    = 6;
  localparam int ALPHA_W  = 8;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_WIDTH_A  = 2'd0,
    REG_HEIGHT_A = 2'd1,
    REG_WIDTH_B  = 2'd2,
    REG_HEIGHT_B = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_SETUP,
    ST_BOUNDS,
    ST_SCAN,
    ST_DONE
  } state_t;

  function automatic logic [SIZE_W-1:0] side_sat(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (int'(v) > MAX_SIDE) begin
      r = SIZE_W'(MAX_SIDE);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/smc_ram.sv @@
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/sprite_mask_collision.sv @@
// ----------------------------------------------------------------------------
// sprite_mask_collision
// Pixel-exact collision test between two sprites held as row-wide opacity
// masks. A check scans the overlap one mask row per cycle through a shared
// shift-and-AND unit.
// ----------------------------------------------------------------------------
// Load: each transfer does a row read-modify-write in the mask RAM
//   (ST_LD_RD, ST_LD_WR) before the next transfer is accepted.
// Check: ST_SETUP, ST_BOUNDS, ST_SCAN over n = overlap rows (1..64), ST_DONE;
//   no ST_SCAN without overlap; next transfer once the result is registered.
// Reset (rst, synchronous): sequencer idle, output empty, sizes zero;
//   mask contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_mask_collision (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [smc_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  opcode,
  input  wire logic [smc_pkg::PIX_W-1:0]   pix_col,
  input  wire logic [smc_pkg::PIX_W-1:0]   pix_row,
  input  wire logic [smc_pkg::ALPHA_W-1:0] alpha,
  input  wire logic [smc_pkg::POS_W-1:0]   pos_a_x,
  input  wire logic [smc_pkg::POS_W-1:0]   pos_a_y,
  input  wire logic [smc_pkg::POS_W-1:0]   pos_b_x,
  input  wire logic [smc_pkg::POS_W-1:0]   pos_b_y,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             collide
);

  localparam int SIDE = smc_pkg::MAX_SIDE;
  localparam int IW   = smc_pkg::IDX_W;
  localparam int SW   = smc_pkg::SIZE_W;
  localparam int PW   = smc_pkg::POS_W;

  smc_pkg::state_t state, state_next;

  logic [smc_pkg::CFG_W-1:0] width_a, height_a, width_b, height_b;

  logic [PW-1:0] ax, ay, bx, by;
  logic [PW:0]   x0, x1, y0, y1;

  logic [IW-1:0] ld_row, ld_col;
  logic          ld_sel_b, ld_en, ld_opaque;

  logic [SIDE-1:0] win;
  logic [IW-1:0]   shamt;
  logic            shift_left;
  logic [IW-1:0]   ra, rb;
  logic [SW-1:0]   left;
  logic            pend;
  logic            hit;

  logic            in_xfer, out_load, issue, overlap;
  logic            we_a, we_b;
  logic [IW-1:0]   raddr_a, raddr_b;
  logic [SIDE-1:0] rd_a, rd_b, rd_sel, wdata, b_aligned;
  logic [SIDE:0]   ones_hi, ones_lo;
  logic [PW:0]     lo_full, hi_full, ra_full, rb_full, cnt_full, dx_full;

  assign in_xfer = in_valid && !in_stall;
  assign issue   = (state == smc_pkg::ST_SCAN) && (left != '0);
  assign overlap = (x0 < x1) && (y0 < y1);

  smc_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_mask_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (ld_row),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  smc_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_mask_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (ld_row),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  always_comb begin
    state_next = state;
    case (state)
      smc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            smc_pkg::OP_LOAD_A, smc_pkg::OP_LOAD_B: state_next = smc_pkg::ST_LD_RD;
            smc_pkg::OP_CHECK:                      state_next = smc_pkg::ST_SETUP;
            default:                                state_next = smc_pkg::ST_IDLE;
          endcase
        end
      end
      smc_pkg::ST_LD_RD:  state_next = smc_pkg::ST_LD_WR;
      smc_pkg::ST_LD_WR:  state_next = smc_pkg::ST_IDLE;
      smc_pkg::ST_SETUP:  state_next = smc_pkg::ST_BOUNDS;
      smc_pkg::ST_BOUNDS: state_next = overlap ? smc_pkg::ST_SCAN : smc_pkg::ST_DONE;
      smc_pkg::ST_SCAN: begin
        if (left == '0 && !pend) begin
          state_next = smc_pkg::ST_DONE;
        end
      end
      smc_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = smc_pkg::ST_IDLE;
        end
      end
      default: state_next = smc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != smc_pkg::ST_IDLE);
    out_load = (state == smc_pkg::ST_DONE) && (!out_valid || !out_stall);
    raddr_a  = issue ? ra : ld_row;
    raddr_b  = issue ? rb : ld_row;
    we_a     = (state == smc_pkg::ST_LD_WR) && ld_en && !ld_sel_b;
    we_b     = (state == smc_pkg::ST_LD_WR) && ld_en && ld_sel_b;
    rd_sel   = ld_sel_b ? rd_b : rd_a;
    wdata    = rd_sel;
    wdata[ld_col] = ld_opaque;
    b_aligned = shift_left ? (rd_b << shamt) : (rd_b >> shamt);
  end

  always_comb begin
    lo_full  = x0 - {1'b0, ax};
    hi_full  = x1 - {1'b0, ax};
    ra_full  = y0 - {1'b0, ay};
    rb_full  = y0 - {1'b0, by};
    cnt_full = y1 - y0;
    dx_full  = (bx >= ax) ? ({1'b0, bx} - {1'b0, ax}) : ({1'b0, ax} - {1'b0, bx});
    ones_hi  = ((SIDE + 1)'(1) << hi_full[SW-1:0]) - (SIDE + 1)'(1);
    ones_lo  = ((SIDE + 1)'(1) << lo_full[SW-1:0]) - (SIDE + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smc_pkg::ST_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      left      <= '0;
      width_a   <= '0;
      height_a  <= '0;
      width_b   <= '0;
      height_b  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          smc_pkg::REG_WIDTH_A:  width_a  <= cfg_data;
          smc_pkg::REG_HEIGHT_A: height_a <= cfg_data;
          smc_pkg::REG_WIDTH_B:  width_b  <= cfg_data;
          smc_pkg::REG_HEIGHT_B: height_b <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      pend <= issue;
      if (state == smc_pkg::ST_BOUNDS) begin
        left <= overlap ? cnt_full[SW-1:0] : '0;
      end else if (issue) begin
        left <= left - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ld_row    <= IW'(pix_row);
      ld_col    <= IW'(pix_col);
      ld_sel_b  <= (opcode == smc_pkg::OP_LOAD_B);
      ld_en     <= (int'(pix_row) < SIDE) && (int'(pix_col) < SIDE);
      ld_opaque <= (alpha != '0);
      ax <= pos_a_x;
      ay <= pos_a_y;
      bx <= pos_b_x;
      by <= pos_b_y;
    end
    if (out_load) begin
      collide <= hit;
    end
    case (state)
      smc_pkg::ST_SETUP: begin
        hit <= 1'b0;
        x0  <= (ax > bx) ? {1'b0, ax} : {1'b0, bx};
        y0  <= (ay > by) ? {1'b0, ay} : {1'b0, by};
        x1  <= (({1'b0, ax} + (PW + 1)'(smc_pkg::side_sat(width_a))) <
                ({1'b0, bx} + (PW + 1)'(smc_pkg::side_sat(width_b)))) ?
               ({1'b0, ax} + (PW + 1)'(smc_pkg::side_sat(width_a))) :
               ({1'b0, bx} + (PW + 1)'(smc_pkg::side_sat(width_b)));
        y1  <= (({1'b0, ay} + (PW + 1)'(smc_pkg::side_sat(height_a))) <
                ({1'b0, by} + (PW + 1)'(smc_pkg::side_sat(height_b)))) ?
               ({1'b0, ay} + (PW + 1)'(smc_pkg::side_sat(height_a))) :
               ({1'b0, by} + (PW + 1)'(smc_pkg::side_sat(height_b)));
      end
      smc_pkg::ST_BOUNDS: begin
        win        <= ones_hi[SIDE-1:0] & ~ones_lo[SIDE-1:0];
        shamt      <= dx_full[IW-1:0];
        shift_left <= (bx >= ax);
        ra         <= ra_full[IW-1:0];
        rb         <= rb_full[IW-1:0];
      end
      smc_pkg::ST_SCAN: begin
        if (issue) begin
          ra <= ra + IW'(1);
          rb <= rb + IW'(1);
        end
        if (pend) begin
          hit <= hit | (|(rd_a & b_aligned & win));
        end
      end
      default: ;
    endcase
  end

  a_check_enters_setup: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && opcode == smc_pkg::OP_CHECK) |=> state == smc_pkg::ST_SETUP)
    else $error("check transfer did not start the sequencer");

  a_single_mask_write: assert property (@(posedge clk) disable iff (rst)
    (we_a || we_b) |-> (state == smc_pkg::ST_LD_WR && !(we_a && we_b)))
    else $error("mask write outside load write step");

  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    (state == smc_pkg::ST_DONE) |-> (!pend && left == '0))
    else $error("result stage reached with rows still in flight");

  a_result_on_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == smc_pkg::ST_DONE))
    else $error("result presented without a finished check");

endmodule

`default_nettype wire
